// ----- design/ecgr_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ecgr_pkg - shared types and constants of the ECG R-peak detector
// Field widths, register reset values, register index codes and the
// structs passed between the pipeline stages.
// -----------------------------------------------------------------------------
package ecgr_pkg;

	// default filter windows
	localparam int unsigned HP_WINDOW_DEF = 1;
	localparam int unsigned LP_WINDOW_DEF = 6;

	// field and state widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SQ_W     = 32;  // square of a 16-bit magnitude
	localparam int unsigned ENERGY_W = 35;
	localparam int unsigned THR_W    = 36;
	localparam int unsigned WMAX_W   = 37;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned Q16_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ENERGY_W-1:0]      ENERGY_MAX   = '1;
	localparam logic [THR_W-1:0]         THR_MAX      = '1;
	localparam logic signed [WMAX_W-1:0] WMAX_RESTART = -37'sd10000;

	// register reset values
	localparam logic [CNT_W-1:0] WINDOW_LEN_RST  = 8'd10;
	localparam logic [CNT_W-1:0] HOLDOFF_LEN_RST = 8'd100;
	localparam logic [Q16_W-1:0] PEAK_WEIGHT_RST = 16'd631;
	localparam logic [Q16_W-1:0] FORGET_RST      = 16'd3604;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN  = 2'd0,
		REG_HOLDOFF_LEN = 2'd1,
		REG_PEAK_WEIGHT = 2'd2,
		REG_FORGET      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] window_len;
		logic [CNT_W-1:0] holdoff_len;
		logic [Q16_W-1:0] peak_weight;
		logic [Q16_W-1:0] forget;
	} cfg_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic start;    // clear the stage state before this item
		logic lp_fill;  // moving sum is full, energy is valid
		logic seed;     // still inside the threshold seeding window
	} stage_flags_t;

endpackage
`default_nettype wire

// ----- design/ecg_r_peak_detector.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ecg_r_peak_detector - QRS (R-peak) detector for a 16-bit ECG stream
// One sample in, one result (beat flag, energy) out, four pipeline stages.
// -----------------------------------------------------------------------------
// Takes one ECG sample per transfer and returns one result per sample, in
// order: a beat flag and the moving energy. The block sustains one sample per
// clock while the result side is not stalled; each sample passes through the
// stage 1 to 4 registers and then the result register, and the pipeline keeps
// taking samples while a finished result waits, stalling the input only when
// all four stages and the result register are full. Stage 4 sets the rate:
// there the threshold feeds back on itself through the Q0.16 update
// multipliers every sample. Assert start_req with the first sample of a
// record to clear all filter and threshold state; the configuration registers
// keep their values. Write configuration only while no samples are in flight.
// -----------------------------------------------------------------------------
module ecg_r_peak_detector #(
	parameter int unsigned HP_WINDOW = ecgr_pkg::HP_WINDOW_DEF,  // 1..16
	parameter int unsigned LP_WINDOW = ecgr_pkg::LP_WINDOW_DEF   // 1..32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// sample channel
	input  wire logic                                 smp_valid,
	output      logic                                 smp_stall,
	input  wire logic signed [ecgr_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                 start_req,
	// result channel
	output      logic                                 res_valid,
	input  wire logic                                 res_stall,
	output      logic                                 beat,
	output      logic [ecgr_pkg::ENERGY_W-1:0]        energy,
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [ecgr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ecgr_pkg::Q16_W-1:0]           cfg_data
);

	ecgr_pkg::cfg_t cfg;

	// stage valids, result valid
	logic v_s1, v_s2, v_s3, v_s4;
	logic res_valid_q;

	// moves out of each stage
	logic go_s1, go_s2, go_s3, go_s4;
	logic take;

	// input register
	logic signed [ecgr_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                 start_s1;

	logic [ecgr_pkg::SQ_W-1:0]     sq_s3;
	ecgr_pkg::stage_flags_t        flags_s3;
	logic [ecgr_pkg::ENERGY_W-1:0] eval_s4;
	ecgr_pkg::stage_flags_t        flags_s4;

	// config: always ready, every write is accepted
	assign cfg_ready = 1'b1;

	ecgr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Pipeline flow: a stage moves forward when the next slot is empty or
	// is itself moving, so bubbles close up behind a stalled result.
	always_comb begin
		go_s4     = v_s4 && (!res_valid_q || !res_stall);
		go_s3     = v_s3 && (!v_s4 || go_s4);
		go_s2     = v_s2 && (!v_s3 || go_s3);
		go_s1     = v_s1 && (!v_s2 || go_s2);
		smp_stall = v_s1 && !go_s1;
		take      = smp_valid && !smp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= take || (v_s1 && !go_s1);
			v_s2        <= go_s1 || (v_s2 && !go_s2);
			v_s3        <= go_s2 || (v_s3 && !go_s3);
			v_s4        <= go_s3 || (v_s4 && !go_s4);
			res_valid_q <= go_s4 || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
			start_s1  <= start_req;
		end
	end

	// stages 1-2: high-pass and squaring
	ecgr_highpass #(
		.HP_WINDOW (HP_WINDOW),
		.LP_WINDOW (LP_WINDOW)
	) u_hp (
		.clk        (clk),
		.arst_n     (arst_n),
		.window_len (cfg.window_len),
		.go_s1      (go_s1),
		.go_s2      (go_s2),
		.sample_s1  (sample_s1),
		.start_s1   (start_s1),
		.sq_s3      (sq_s3),
		.flags_s3   (flags_s3)
	);

	// stage 3: moving sum of squares
	ecgr_energy #(
		.LP_WINDOW (LP_WINDOW)
	) u_energy (
		.clk      (clk),
		.arst_n   (arst_n),
		.go_s3    (go_s3),
		.sq_s3    (sq_s3),
		.flags_s3 (flags_s3),
		.eval_s4  (eval_s4),
		.flags_s4 (flags_s4)
	);

	// stage 4: threshold, hold-off, result register
	ecgr_threshold u_thr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.go_s4    (go_s4),
		.eval_s4  (eval_s4),
		.flags_s4 (flags_s4),
		.beat_q   (beat),
		.energy_q (energy)
	);

	assign res_valid = res_valid_q;

	// a beat needs energy above a nonnegative threshold
	a_beat_energy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && beat |-> energy != '0)
		else $error("beat reported with zero energy");

	// a new result only comes out of a full stage 4
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(v_s4))
		else $error("result appeared without an item in stage 4");

	// input stalls only when every stage and the result register are held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		smp_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && res_valid && res_stall))
		else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// ----- design/ecgr_cfg_regs.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ecgr_cfg_regs - configuration register file
// Four write-only registers, written through the index/data port.
// -----------------------------------------------------------------------------
module ecgr_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [ecgr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [ecgr_pkg::Q16_W-1:0]      wr_data,
	output      ecgr_pkg::cfg_t                  cfg
);

	ecgr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len  <= ecgr_pkg::WINDOW_LEN_RST;
			cfg_q.holdoff_len <= ecgr_pkg::HOLDOFF_LEN_RST;
			cfg_q.peak_weight <= ecgr_pkg::PEAK_WEIGHT_RST;
			cfg_q.forget      <= ecgr_pkg::FORGET_RST;
		end else if (wr_en) begin
			unique case (ecgr_pkg::reg_idx_t'(wr_index))
				ecgr_pkg::REG_WINDOW_LEN:  cfg_q.window_len  <= wr_data[ecgr_pkg::CNT_W-1:0];
				ecgr_pkg::REG_HOLDOFF_LEN: cfg_q.holdoff_len <= wr_data[ecgr_pkg::CNT_W-1:0];
				ecgr_pkg::REG_PEAK_WEIGHT: cfg_q.peak_weight <= wr_data;
				ecgr_pkg::REG_FORGET:      cfg_q.forget      <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- design/ecgr_highpass.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ecgr_highpass - moving-average high-pass and squaring (stages 1 and 2)
// Stage 1 updates the sample line and running sum and starts the mean
// division (reciprocal multiply). Stage 2 corrects the quotient, forms the
// high-pass output and squares it.
// -----------------------------------------------------------------------------
module ecgr_highpass #(
	parameter int unsigned HP_WINDOW = ecgr_pkg::HP_WINDOW_DEF,
	parameter int unsigned LP_WINDOW = ecgr_pkg::LP_WINDOW_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [ecgr_pkg::CNT_W-1:0]           window_len,
	input  wire logic                                 go_s1,
	input  wire logic                                 go_s2,
	input  wire logic signed [ecgr_pkg::SAMPLE_W-1:0] sample_s1,
	input  wire logic                                 start_s1,
	output      logic [ecgr_pkg::SQ_W-1:0]            sq_s3,
	output      ecgr_pkg::stage_flags_t               flags_s3
);

	localparam int unsigned SW     = ecgr_pkg::SAMPLE_W;
	localparam int unsigned SUM_W  = SW + $clog2(HP_WINDOW + 1);
	localparam int unsigned K      = SUM_W + 1;
	localparam int unsigned RCP_W  = K + 1;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((2 ** K) / HP_WINDOW);
	localparam int unsigned PROD_W = SUM_W + RCP_W;
	localparam int unsigned QN_W   = SUM_W + 5;
	localparam int unsigned MID    = (HP_WINDOW + 1) / 2;
	localparam int unsigned HPO_W  = SW + 1;

	// stage 1 state
	logic signed [SW-1:0]     hist_q [HP_WINDOW];
	logic signed [SUM_W-1:0]  sum_q;
	logic [ecgr_pkg::CNT_W-1:0] cnt_q;

	logic signed [SW-1:0]     hist_cur [HP_WINDOW];
	logic signed [SUM_W-1:0]  sum_cur;
	logic signed [SUM_W-1:0]  sum_new;
	logic [ecgr_pkg::CNT_W-1:0] cnt_cur;
	logic [ecgr_pkg::CNT_W-1:0] cnt_next;
	logic [SUM_W-1:0]         mag;
	logic [PROD_W-1:0]        prod;
	logic                     hp_fill;
	ecgr_pkg::stage_flags_t   flags;

	// stage 2 registers
	logic [SUM_W-1:0]         mag_s2;
	logic [SUM_W-1:0]         qe_s2;
	logic                     neg_s2;
	logic signed [SW-1:0]     mid_s2;
	logic                     hp_fill_s2;
	ecgr_pkg::stage_flags_t   flags_s2;

	logic [QN_W-1:0]          rem;
	logic [SUM_W-1:0]         quot;
	logic signed [HPO_W-1:0]  mean;
	logic signed [HPO_W-1:0]  hp;
	logic [HPO_W-1:0]         hp_neg;
	logic [SW-1:0]            hp_mag;

	always_comb begin
		for (int k = 0; k < HP_WINDOW; k++) begin
			hist_cur[k] = start_s1 ? '0 : hist_q[k];
		end
		sum_cur  = start_s1 ? '0 : sum_q;
		cnt_cur  = start_s1 ? '0 : cnt_q;
		sum_new  = sum_cur + SUM_W'(sample_s1) - SUM_W'(hist_cur[HP_WINDOW-1]);
		cnt_next = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
		mag      = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
		prod     = PROD_W'(mag) * PROD_W'(RECIP);
		hp_fill  = cnt_cur >= ecgr_pkg::CNT_W'(HP_WINDOW);
		flags.start   = start_s1;
		flags.lp_fill = cnt_cur >= ecgr_pkg::CNT_W'(LP_WINDOW);
		flags.seed    = cnt_cur < window_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HP_WINDOW; k++) begin
				hist_q[k] <= '0;
			end
			sum_q <= '0;
			cnt_q <= '0;
		end else if (go_s1) begin
			hist_q[0] <= sample_s1;
			for (int k = 1; k < HP_WINDOW; k++) begin
				hist_q[k] <= hist_cur[k-1];
			end
			sum_q <= sum_new;
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			mag_s2     <= mag;
			qe_s2      <= SUM_W'(prod >> K);
			neg_s2     <= sum_new[SUM_W-1];
			mid_s2     <= (MID == 0) ? sample_s1 : hist_cur[MID-1];
			hp_fill_s2 <= hp_fill;
			flags_s2   <= flags;
		end
	end

	// quotient estimate is low by at most one
	always_comb begin
		rem    = QN_W'(mag_s2) - QN_W'(qe_s2) * QN_W'(HP_WINDOW);
		quot   = (rem >= QN_W'(HP_WINDOW)) ? qe_s2 + 1'b1 : qe_s2;
		mean   = neg_s2 ? -$signed(HPO_W'(quot)) : $signed(HPO_W'(quot));
		hp     = hp_fill_s2 ? {mid_s2[SW-1], mid_s2} - mean : '0;
		hp_neg = -hp;
		hp_mag = hp[HPO_W-1] ? hp_neg[SW-1:0] : hp[SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			sq_s3    <= ecgr_pkg::SQ_W'(hp_mag) * ecgr_pkg::SQ_W'(hp_mag);
			flags_s3 <= flags_s2;
		end
	end

endmodule
`default_nettype wire

// ----- design/ecgr_energy.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ecgr_energy - moving sum of squares (stage 3)
// Keeps the last LP_WINDOW squares and a running sum; saturates the result.
// -----------------------------------------------------------------------------
module ecgr_energy #(
	parameter int unsigned LP_WINDOW = ecgr_pkg::LP_WINDOW_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            go_s3,
	input  wire logic [ecgr_pkg::SQ_W-1:0]       sq_s3,
	input  wire ecgr_pkg::stage_flags_t          flags_s3,
	output      logic [ecgr_pkg::ENERGY_W-1:0]   eval_s4,
	output      ecgr_pkg::stage_flags_t          flags_s4
);

	localparam int unsigned SQW   = ecgr_pkg::SQ_W;
	localparam int unsigned EW    = ecgr_pkg::ENERGY_W;
	localparam int unsigned ESUM_W = SQW + $clog2(LP_WINDOW + 1);
	localparam int unsigned EXT_W = (ESUM_W > EW) ? ESUM_W : EW + 1;

	logic [SQW-1:0]    line_q [LP_WINDOW];
	logic [ESUM_W-1:0] esum_q;

	logic [SQW-1:0]    line_cur [LP_WINDOW];
	logic [ESUM_W-1:0] esum_new;
	logic [EXT_W-1:0]  esum_ext;
	logic [EW-1:0]     eval;

	always_comb begin
		for (int k = 0; k < LP_WINDOW; k++) begin
			line_cur[k] = flags_s3.start ? '0 : line_q[k];
		end
		esum_new = (flags_s3.start ? '0 : esum_q) + ESUM_W'(sq_s3)
			- ESUM_W'(line_cur[LP_WINDOW-1]);
		esum_ext = EXT_W'(esum_new);
		if (!flags_s3.lp_fill) begin
			eval = '0;
		end else if (esum_ext > EXT_W'(ecgr_pkg::ENERGY_MAX)) begin
			eval = ecgr_pkg::ENERGY_MAX;
		end else begin
			eval = esum_ext[EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LP_WINDOW; k++) begin
				line_q[k] <= '0;
			end
			esum_q <= '0;
		end else if (go_s3) begin
			line_q[0] <= sq_s3;
			for (int k = 1; k < LP_WINDOW; k++) begin
				line_q[k] <= line_cur[k-1];
			end
			esum_q <= esum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s3) begin
			eval_s4  <= eval;
			flags_s4 <= flags_s3;
		end
	end

endmodule
`default_nettype wire

// ----- design/ecgr_threshold.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ecgr_threshold - adaptive threshold, hold-off and beat decision (stage 4)
// Seeds the threshold, tracks the window maximum, runs the periodic Q0.16
// update and drives the result register.
// -----------------------------------------------------------------------------
module ecgr_threshold (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ecgr_pkg::cfg_t                  cfg,
	input  wire logic                            go_s4,
	input  wire logic [ecgr_pkg::ENERGY_W-1:0]   eval_s4,
	input  wire ecgr_pkg::stage_flags_t          flags_s4,
	output      logic                            beat_q,
	output      logic [ecgr_pkg::ENERGY_W-1:0]   energy_q
);

	localparam int unsigned EW  = ecgr_pkg::ENERGY_W;
	localparam int unsigned TW  = ecgr_pkg::THR_W;
	localparam int unsigned WW  = ecgr_pkg::WMAX_W;
	localparam int unsigned CW  = ecgr_pkg::CNT_W;
	localparam int unsigned QW  = ecgr_pkg::Q16_W;
	localparam int unsigned PW_W = QW + EW;        // weight * window max
	localparam int unsigned PT_W = QW + 1 + TW;    // (1 - forget) * threshold
	localparam int unsigned ACC_W = PT_W + 1;
	localparam int unsigned T_W  = ACC_W - QW;

	logic [TW-1:0]        thr_q;
	logic signed [WW-1:0] wm_q;
	logic                 armed_q;
	logic [CW-1:0]        hc_q;
	logic [CW-1:0]        wi_q;

	logic [TW-1:0]        thr0, thr1, thr2, thr_n;
	logic signed [WW-1:0] wm0, wm1, wm_n, eval_ext;
	logic                 armed0, armed1, armed_n;
	logic [CW-1:0]        hc0, hc1, hc_inc, wi0, wi_n;
	logic [TW-1:0]        eval_t;
	logic                 beat;
	logic                 upd;
	logic [EW-1:0]        w;
	logic [QW:0]          fw;
	logic [PW_W-1:0]      prod_w;
	logic [PT_W-1:0]      prod_t;
	logic [ACC_W-1:0]     acc;
	logic [T_W-1:0]       t;

	always_comb begin
		thr0   = flags_s4.start ? '0 : thr_q;
		wm0    = flags_s4.start ? '0 : wm_q;
		armed0 = flags_s4.start ? 1'b0 : armed_q;
		hc0    = flags_s4.start ? '0 : hc_q;
		wi0    = flags_s4.start ? '0 : wi_q;

		eval_t   = TW'(eval_s4);
		eval_ext = $signed(WW'(eval_s4));

		// seeding: largest energy of the first window
		thr1 = (flags_s4.seed && (eval_t > thr0)) ? eval_t : thr0;

		// hold-off counter
		hc_inc = hc0 + 1'b1;
		if (armed0) begin
			if (hc_inc >= cfg.holdoff_len) begin
				armed1 = 1'b0;
				hc1    = '0;
			end else begin
				armed1 = 1'b1;
				hc1    = hc_inc;
			end
		end else begin
			armed1 = 1'b0;
			hc1    = hc0;
		end

		wm1 = (eval_ext > wm0) ? eval_ext : wm0;

		beat    = (eval_t > thr1) && !armed1;
		armed_n = armed1 || beat;

		// periodic update: (pw*max + (1-forget)*thr) >> 16, both terms nonnegative
		upd    = wi0 >= cfg.window_len;
		w      = wm1[WW-1] ? '0 : wm1[EW-1:0];
		fw     = (QW+1)'(1 << QW) - (QW+1)'(cfg.forget);
		prod_w = PW_W'(cfg.peak_weight) * PW_W'(w);
		prod_t = PT_W'(fw) * PT_W'(thr1);
		acc    = ACC_W'(prod_w) + ACC_W'(prod_t);
		t      = acc[ACC_W-1:QW];
		thr2   = (t > T_W'(ecgr_pkg::THR_MAX)) ? ecgr_pkg::THR_MAX : t[TW-1:0];

		if (upd) begin
			thr_n = thr2;
			wm_n  = ecgr_pkg::WMAX_RESTART;
			wi_n  = '0;
		end else begin
			thr_n = thr1;
			wm_n  = wm1;
			wi_n  = wi0 + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			wm_q    <= '0;
			armed_q <= 1'b0;
			hc_q    <= '0;
			wi_q    <= '0;
		end else if (go_s4) begin
			thr_q   <= thr_n;
			wm_q    <= wm_n;
			armed_q <= armed_n;
			hc_q    <= hc1;
			wi_q    <= wi_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s4) begin
			beat_q   <= beat;
			energy_q <= eval_s4;
		end
	end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// -----------------------------------------------------------------------------
// tb - self-checking testbench for ecg_r_peak_detector
// Drives ECG sample records through the detector under random input gaps and
// output stalls, predicts beat flag and energy for every sample with an
// independent fixed-point detector model, and checks each result in order.
// -----------------------------------------------------------------------------
module tb;
	import ecgr_pkg::*;

	localparam int HPW         = HP_WINDOW_DEF;
	localparam int LPW         = LP_WINDOW_DEF;
	localparam int ITEMS       = 600;   // stimulus stops once this many samples went in
	localparam int QUIET_LIMIT = 2000;  // cycles with no transfer at all before giving up

	// beat flag and energy as one result transfer carries them
	typedef struct packed {
		logic                beat;
		logic [ENERGY_W-1:0] energy;
	} beat_rec_t;

	// ---------------------------------------------------------------------
	// clock, reset and block ports; every input has a known value at time 0
	// ---------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                       smp_valid = 1'b0;
	logic                       smp_stall;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       start_req = 1'b0;
	logic                       res_valid;
	logic                       res_stall = 1'b0;
	logic                       beat;
	logic [ENERGY_W-1:0]        energy;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [Q16_W-1:0]           cfg_data  = '0;

	always #2 clk = ~clk;

	ecg_r_peak_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.sample    (sample),
		.start_req (start_req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.beat      (beat),
		.energy    (energy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------------
	// detector model state: a private copy of the registers and of every
	// piece of filter / threshold state the block keeps
	// ---------------------------------------------------------------------
	cfg_t                     cfg_q;
	logic signed [15:0]       x_hist [0:HPW];   // newest sample first
	logic signed [16:0]       hp_hist [0:LPW];  // newest high-pass output first
	logic signed [20:0]       hp_sum;
	logic [35:0]              sq_sum;           // running sum of squares
	logic [THR_W-1:0]         thr;
	logic signed [WMAX_W-1:0] wmax;
	logic                     holdoff_on;
	logic [CNT_W-1:0]         holdoff_cnt;
	logic [CNT_W-1:0]         win_idx;
	logic [CNT_W-1:0]         smp_cnt;          // saturates at 255

	beat_rec_t beat_q[$];   // predicted results, oldest first
	int        n_sent;
	int        n_errors;
	bit        tx_busy;     // sender inserts random gaps
	bit        rx_busy;     // receiver inserts random stalls
	int        stall_left;
	int        quiet_cycles;

	function automatic int draw_wait(input bit busy);
		return busy ? int'($urandom_range(0, 15)) : 0;
	endfunction

	function automatic void clear_detector_state();
		int k;
		for (k = 0; k <= HPW; k++) x_hist[k] = '0;
		for (k = 0; k <= LPW; k++) hp_hist[k] = '0;
		hp_sum      = '0;
		sq_sum      = '0;
		thr         = '0;
		wmax        = '0;
		holdoff_on  = 1'b0;
		holdoff_cnt = '0;
		win_idx     = '0;
		smp_cnt     = '0;
	endfunction

	function automatic void store_reg(input reg_idx_t idx, input logic [Q16_W-1:0] word);
		case (idx)
			REG_WINDOW_LEN:  cfg_q.window_len  = word[CNT_W-1:0];
			REG_HOLDOFF_LEN: cfg_q.holdoff_len = word[CNT_W-1:0];
			REG_PEAK_WEIGHT: cfg_q.peak_weight = word;
			REG_FORGET:      cfg_q.forget      = word;
			default: ;
		endcase
	endfunction

	function automatic logic [33:0] square_mag(input logic signed [16:0] v);
		logic [16:0] m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	// One sample through the detector: returns the beat flag and energy the
	// block must produce for it and advances the model state.
	function automatic beat_rec_t detect_beat(input logic signed [SAMPLE_W-1:0] x,
			input logic st);
		logic signed [16:0]  hp;
		logic [ENERGY_W-1:0] eval;
		logic                hit;
		longint unsigned     w_pos, acc, t;
		beat_rec_t           r;
		int                  k;
		hp   = '0;
		eval = '0;
		hit  = 1'b0;
		if (st)
			clear_detector_state();

		// high-pass: delayed sample minus the truncated window mean
		for (k = HPW; k > 0; k--) x_hist[k] = x_hist[k-1];
		x_hist[0] = x;
		hp_sum = hp_sum + x_hist[0] - x_hist[HPW];
		if (smp_cnt >= HPW)
			hp = 17'(x_hist[(HPW+1)/2] - hp_sum / HPW);

		// squaring and moving sum; zero until the window is full
		for (k = LPW; k > 0; k--) hp_hist[k] = hp_hist[k-1];
		hp_hist[0] = hp;
		sq_sum = sq_sum + square_mag(hp_hist[0]) - square_mag(hp_hist[LPW]);
		if (smp_cnt >= LPW)
			eval = (sq_sum > ENERGY_MAX) ? ENERGY_MAX : sq_sum[ENERGY_W-1:0];

		// seeding: threshold tracks the peak energy of the first window
		if (smp_cnt < cfg_q.window_len && eval > thr)
			thr = THR_W'(eval);

		if (holdoff_on) begin
			holdoff_cnt = holdoff_cnt + 8'd1;
			if (holdoff_cnt >= cfg_q.holdoff_len) begin
				holdoff_on  = 1'b0;
				holdoff_cnt = '0;
			end
		end

		if ($signed({2'b00, eval}) > wmax)
			wmax = {2'b00, eval};

		if (eval > thr && !holdoff_on) begin
			hit        = 1'b1;
			holdoff_on = 1'b1;
		end

		// periodic Q0.16 threshold update, floor, saturating
		if (win_idx >= cfg_q.window_len) begin
			w_pos = (wmax < 0) ? 64'd0 : 64'(wmax);
			acc   = 64'(cfg_q.peak_weight) * w_pos
			      + (64'd65536 - 64'(cfg_q.forget)) * 64'(thr);
			t     = acc >> 16;
			thr   = (t > 64'(THR_MAX)) ? THR_MAX : t[THR_W-1:0];
			win_idx = '0;
			wmax    = WMAX_RESTART;
		end else begin
			win_idx = win_idx + 8'd1;
		end

		if (smp_cnt != 8'd255)
			smp_cnt = smp_cnt + 8'd1;

		r.beat   = hit;
		r.energy = eval;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// sample channel driver: optional gap, then hold the sample until the
	// transfer; valid stays up so a back-to-back sample needs no re-raise
	// ---------------------------------------------------------------------
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic st);
		int gap;
		gap = draw_wait(tx_busy);
		if (gap > 0) begin
			smp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_valid <= 1'b1;
		sample    <= s;
		start_req <= st;
		do @(posedge clk); while (smp_stall);
		beat_q.push_back(detect_beat(s, st));
		n_sent++;
	endtask

	// drop valid and wait for every predicted result to come back
	task automatic drain();
		smp_valid <= 1'b0;
		while (beat_q.size() != 0) @(posedge clk);
	endtask

	// writes all four registers; the unused upper byte of the 8-bit ones
	// carries random junk that must be dropped
	task automatic load_cfg(input cfg_t c);
		logic [Q16_W-1:0] word;
		reg_idx_t         idx;
		int               k;
		for (k = 0; k < 4; k++) begin
			idx = reg_idx_t'(k);
			case (idx)
				REG_WINDOW_LEN:  word = {8'($urandom), c.window_len};
				REG_HOLDOFF_LEN: word = {8'($urandom), c.holdoff_len};
				REG_PEAK_WEIGHT: word = c.peak_weight;
				default:         word = c.forget;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= word;
			do @(posedge clk); while (!cfg_ready);
			store_reg(idx, word);
		end
		cfg_valid <= 1'b0;
	endtask

	// One ECG-like record: a noisy baseline with a periodic R spike and a
	// following undershoot, or plain full-range noise; both kinds have stray restarts.
	task automatic play_record(input int len, input bit pulsed, input bit fresh);
		int   period, phase, amp, nz, v, k;
		logic st;
		period = $urandom_range(6, 40);
		phase  = $urandom_range(0, period - 1);
		amp    = $urandom_range(1000, 32767);
		if ($urandom_range(0, 1) != 0)
			amp = -amp;
		nz     = $urandom_range(0, 800);
		for (k = 0; k < len && n_sent < ITEMS; k++) begin
			st = (k == 0) ? fresh : ($urandom_range(0, 63) == 0);
			if (pulsed) begin
				v = int'($urandom_range(0, 2 * nz)) - nz;
				if (k % period == phase)
					v += amp;
				else if (k % period == (phase + 1) % period)
					v -= amp / 2;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				send_sample(16'(v), st);
			end else begin
				send_sample(16'($urandom), st);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// Reset register values, full-scale swings (largest high-pass output and
	// energy), sign boundaries and a restart in the middle of a record.
	task automatic test_field_extremes();
		tx_busy = 1'b0;
		rx_busy = 1'b0;
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sd1,   1'b0);
		send_sample(16'sd1,    1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b0);
	endtask

	// Zero window and hold-off lengths written over running counters (they
	// must complete at once), full peak weight and no forgetting so the
	// threshold climbs into saturation on full-scale energy.
	task automatic test_degenerate_regs();
		cfg_t c;
		int   k;
		tx_busy = 1'b1;
		rx_busy = 1'b1;
		drain();
		c.window_len  = 8'd0;
		c.holdoff_len = 8'd0;
		c.peak_weight = 16'hFFFF;
		c.forget      = 16'h0000;
		load_cfg(c);
		send_sample(16'sd1000, 1'b0);
		send_sample(-16'sd1000, 1'b0);
		for (k = 0; k < 9; k++)
			send_sample(k[0] ? 16'sh8000 : 16'sh7FFF, 1'b0);
	endtask

	// Random phases: new register set (first the two all-extreme sets), new
	// idle behavior, then a few records that may or may not restart state.
	task automatic test_random_records();
		cfg_t c;
		int   phase_no, n_rec;
		phase_no = 0;
		while (n_sent < ITEMS) begin
			if (phase_no == 0 || $urandom_range(0, 7) == 0) begin
				c.window_len  = 8'd255;
				c.holdoff_len = 8'd255;
				c.peak_weight = 16'h0000;
				c.forget      = 16'hFFFF;
			end else if (phase_no == 1 || $urandom_range(0, 7) == 0) begin
				c.window_len  = 8'd0;
				c.holdoff_len = 8'd0;
				c.peak_weight = 16'h0000;
				c.forget      = 16'h0000;
			end else if ($urandom_range(0, 7) == 0) begin
				c = {WINDOW_LEN_RST, HOLDOFF_LEN_RST, PEAK_WEIGHT_RST, FORGET_RST};
			end else begin
				// short windows and hold-offs keep beats coming in short records
				c.window_len  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
				                                           : 8'($urandom_range(0, 40));
				c.holdoff_len = ($urandom_range(0, 3) == 0) ? 8'($urandom)
				                                           : 8'($urandom_range(0, 60));
				c.peak_weight = 16'($urandom);
				c.forget      = 16'($urandom);
			end
			drain();
			tx_busy = ($urandom_range(0, 3) != 0);
			rx_busy = ($urandom_range(0, 3) != 0);
			load_cfg(c);
			n_rec = $urandom_range(1, 3);
			repeat (n_rec)
				play_record($urandom_range(15, 80), $urandom_range(0, 3) != 0,
					$urandom_range(0, 3) != 0);
			phase_no++;
		end
	endtask

	// ---------------------------------------------------------------------
	// result side: random stall after each transfer, in-order comparison
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		beat_rec_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (beat_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, beat %0b energy %0d",
					$time, beat, energy);
			end else begin
				want = beat_q.pop_front();
				if (beat !== want.beat) begin
					n_errors++;
					$display("%0t: beat mismatch, expected %0b, actual %0b",
						$time, want.beat, beat);
				end
				if (energy !== want.energy) begin
					n_errors++;
					$display("%0t: energy mismatch, expected %0d, actual %0d",
						$time, want.energy, energy);
				end
			end
			stall_left = draw_wait(rx_busy);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		res_stall <= (stall_left != 0);
	end

	// watchdog: any transfer on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (smp_valid && !smp_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		n_sent       = 0;
		n_errors     = 0;
		stall_left   = 0;
		quiet_cycles = 0;
		tx_busy      = 1'b0;
		rx_busy      = 1'b0;
		cfg_q = {WINDOW_LEN_RST, HOLDOFF_LEN_RST, PEAK_WEIGHT_RST, FORGET_RST};
		clear_detector_state();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_degenerate_regs();
		test_random_records();

		// let the pipeline empty, then watch a little longer for strays
		drain();
		repeat (16) @(posedge clk);

		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/ecgr_pkg.sv
design/ecgr_cfg_regs.sv
design/ecgr_highpass.sv
design/ecgr_energy.sv
design/ecgr_threshold.sv
design/ecg_r_peak_detector.sv
sim/tb.sv
